// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/lde_pkg.sv =====
// ----------------------------------------------------------------------------
// lde_pkg
// Types and constants shared by the link delay and loss emulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lde_pkg;

  localparam int unsigned TIME_W      = 48;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned STATUS_W    = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned STPB_W      = 40;
  localparam int unsigned BURST_CNT_W = 8;
  localparam int unsigned LAT_W       = 32;

  // Transmit time is (time_per_byte * length) >> TX_SHIFT.
  localparam int unsigned TX_SHIFT  = 20;
  localparam int unsigned TX_PROD_W = STPB_W + LEN_W;

  localparam int unsigned MAX_LEN_RESET = 1536;

  // Burst window = burst_count * time_per_byte * BURST_BYTES / BURST_DIVISOR.
  localparam int unsigned BURST_BYTES   = 1536;
  localparam int unsigned BURST_DIVISOR = 1000000;
  localparam int unsigned WIN_PROD_W    = STPB_W + BURST_CNT_W;
  localparam int unsigned WAIT_W        = 40;

  // The ratio 1536 / 1000000 reduces to 24 / 15625, so the window unit scales
  // by 24 and divides by 15625, one 16-bit quotient digit at a time.
  localparam int unsigned WIN_SCALE    = BURST_BYTES / 64;
  localparam int unsigned WIN_DIVISOR  = BURST_DIVISOR / 64;
  localparam int unsigned DVD_W        = 64;
  localparam int unsigned DIGIT_W      = 16;
  localparam int unsigned NUM_DIGITS   = DVD_W / DIGIT_W;
  localparam int unsigned DIGIT_CNT_W  = $clog2(NUM_DIGITS);
  localparam int unsigned WIN_REM_W    = 14;
  localparam int unsigned EST_W        = WIN_REM_W + DIGIT_W;

  // A partial dividend is below 2^30; with this rounded-up reciprocal of the
  // divisor, (part * WIN_RECIP) >> WIN_RECIP_SH is its exact quotient.
  localparam int unsigned WIN_RECIP_SH = EST_W + WIN_REM_W;
  localparam int unsigned RECIP_W      = 31;
  localparam longint unsigned WIN_RECIP =
      ((64'd1 << WIN_RECIP_SH) + 64'(WIN_DIVISOR) - 64'd1) / 64'(WIN_DIVISOR);
  localparam int unsigned EST_PROD_W   = EST_W + RECIP_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED       = 4'd0,
    ST_TAIL_DROP    = 4'd1,
    ST_FIFO_FULL    = 4'd2,
    ST_OVERSIZE     = 4'd3,
    ST_PATTERN_LOSS = 4'd4,
    ST_LINK_OFF     = 4'd5,
    ST_BURST_LOSS   = 4'd6,
    ST_DELIVERED    = 4'd7,
    ST_NONE_DUE     = 4'd8
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_PER_BYTE   = 3'd0,
    CFG_LINK_LATENCY    = 3'd1,
    CFG_MAX_QUEUE_DELAY = 3'd2,
    CFG_MAX_PKT_LEN     = 3'd3,
    CFG_BURST_COUNT     = 3'd4,
    CFG_BURST_SPACING   = 3'd5,
    CFG_LOSS_PATTERN    = 3'd6,
    CFG_LINK_OFF        = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    KIND_SUBMIT = 1'b0,
    KIND_POLL   = 1'b1
  } kind_e;

  typedef enum logic {
    CORE_IDLE,
    CORE_EXEC
  } core_state_e;

  typedef enum logic [2:0] {
    WIN_IDLE,
    WIN_MUL,
    WIN_LOAD,
    WIN_EST,
    WIN_FIX
  } win_state_e;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [LEN_W-1:0]  length;
    logic [TAG_W-1:0]  tag;
  } fifo_entry_t;

endpackage

`default_nettype wire

// ===== src/lde_ram.sv =====
// ----------------------------------------------------------------------------
// lde_ram
// Packet queue storage: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lde_ram
  import lde_pkg::*;
#(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire fifo_entry_t       wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output fifo_entry_t            rd_data_o
);

  fifo_entry_t mem [DEPTH];
  fifo_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/lde_win.sv =====
// ----------------------------------------------------------------------------
// lde_win
// Burst window unit: recomputes count * time_per_byte * 1536 / 1000000 by a
// reciprocal multiplication, one 16-bit quotient digit at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lde_win
  import lde_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   recalc_i,
  input  wire logic [STPB_W-1:0]      time_per_byte_i,
  input  wire logic [BURST_CNT_W-1:0] burst_count_i,
  output logic                        busy_o,
  output logic [WAIT_W-1:0]           wait_o
);

  win_state_e              state_q, state_d;
  logic [DIGIT_CNT_W-1:0]  cnt_q, cnt_d;
  logic [WAIT_W-1:0]       wait_q, wait_d;
  logic [WIN_PROD_W-1:0]   prod_q, prod_d;
  logic [DVD_W-1:0]        dvd_q, dvd_d;
  logic [WIN_REM_W-1:0]    rem_q, rem_d;
  logic [DIGIT_W-1:0]      digit_q, digit_d;
  logic [WAIT_W-1:0]       quot_q, quot_d;
  logic [EST_W-1:0]        part;
  logic [EST_PROD_W-1:0]   est;
  logic [EST_W-1:0]        back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WIN_IDLE;
      cnt_q   <= '0;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    digit_q <= digit_d;
    quot_q  <= quot_d;
  end

  // The remainder stays below the divisor, so each quotient digit fits in
  // sixteen bits and the new remainder in fourteen.
  assign part = {rem_q, dvd_q[DVD_W-1 -: DIGIT_W]};
  assign est  = EST_PROD_W'(part) * EST_PROD_W'(RECIP_W'(WIN_RECIP));
  assign back = part - EST_W'(digit_q) * EST_W'(WIN_DIVISOR);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    wait_d  = wait_q;
    prod_d  = prod_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    digit_d = digit_q;
    quot_d  = quot_q;
    case (state_q)
      WIN_IDLE: begin
      end
      WIN_MUL: begin
        prod_d  = WIN_PROD_W'(burst_count_i) * WIN_PROD_W'(time_per_byte_i);
        state_d = WIN_LOAD;
      end
      WIN_LOAD: begin
        // Constant factor: synthesis reduces this to two shifted adds.
        dvd_d   = DVD_W'(prod_q) * DVD_W'(WIN_SCALE);
        rem_d   = '0;
        quot_d  = '0;
        cnt_d   = '0;
        state_d = WIN_EST;
      end
      WIN_EST: begin
        digit_d = est[WIN_RECIP_SH +: DIGIT_W];
        state_d = WIN_FIX;
      end
      WIN_FIX: begin
        // The true quotient is below 2^40, so shifting out the top is safe.
        rem_d  = back[WIN_REM_W-1:0];
        quot_d = {quot_q[WAIT_W-DIGIT_W-1:0], digit_q};
        dvd_d  = dvd_q << DIGIT_W;
        cnt_d  = cnt_q + DIGIT_CNT_W'(1);
        if (cnt_q == DIGIT_CNT_W'(NUM_DIGITS - 1)) begin
          wait_d  = {quot_q[WAIT_W-DIGIT_W-1:0], digit_q};
          state_d = WIN_IDLE;
        end else begin
          state_d = WIN_EST;
        end
      end
      default: begin
        state_d = WIN_IDLE;
      end
    endcase
    if (recalc_i) begin
      state_d = WIN_MUL;
    end
  end

  assign busy_o = (state_q != WIN_IDLE);
  assign wait_o = wait_q;

endmodule

`default_nettype wire

// ===== src/link_delay_loss_emulator.sv =====
// ----------------------------------------------------------------------------
// link_delay_loss_emulator
// One-way link model: serialization queue clock, tail drop, pattern, switch
// and burst loss, and a delay FIFO drained by poll commands.
// ----------------------------------------------------------------------------
// In the cycle that ends with a command's accept edge the queue head is read
// from the packet memory and the transmit-time product is formed; in the next
// cycle the command is evaluated, the memory and state are written back and the
// word is registered. The word is on the result ports for one cycle with done_o
// high, and busy_o is already low in that cycle unless the burst window unit is
// busy, so a new command can then be accepted while the word is shown. The
// receiver cannot stall and must take each word when done_o is high. A write to
// the time-per-byte or burst-count register recomputes the burst window by a
// reciprocal multiplication, one 16-bit quotient digit at a time; busy_o stays
// high after such a write until the new window is ready.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module link_delay_loss_emulator
  import lde_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  kind_i,
  input  wire logic [TIME_W-1:0]     now_i,
  input  wire logic [LEN_W-1:0]      packet_length_i,
  input  wire logic [TAG_W-1:0]      packet_tag_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [TAG_W-1:0]           out_tag_o,
  output logic [LEN_W-1:0]           out_length_o,
  output logic [TIME_W-1:0]          arrival_stamp_o,
  output logic [CNT_W-1:0]           drop_total_o
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [TIME_W-1:0] sat_add_time(input logic [TIME_W-1:0] a,
                                                     input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // Configuration registers.
  logic [STPB_W-1:0]      tpb_q;
  logic [LAT_W-1:0]       latency_q;
  logic [CNT_W-1:0]       max_delay_q;
  logic [LEN_W-1:0]       max_len_q;
  logic [BURST_CNT_W-1:0] burst_cnt_q;
  logic [CNT_W-1:0]       burst_gap_q;
  logic                   link_off_q;

  // Link and queue state.
  core_state_e            state_q, state_d;
  logic [TIME_W-1:0]      qc_q, qc_d;
  logic [CNT_W-1:0]       sent_q, sent_d;
  logic [CNT_W-1:0]       dropped_q, dropped_d;
  logic [63:0]            rot_q, rot_d;
  logic [CNT_W-1:0]       mark_q, mark_d;
  logic [BURST_CNT_W-1:0] left_q, left_d;
  logic [TIME_W-1:0]      bend_q, bend_d;
  logic [PTR_W-1:0]       head_q, head_d;
  logic [PTR_W-1:0]       tail_q, tail_d;
  logic [FILL_W-1:0]      fill_q, fill_d;

  // Command captured at accept.
  kind_e                  kind_q;
  logic [TIME_W-1:0]      now_q;
  logic [LEN_W-1:0]       len_q;
  logic [TAG_W-1:0]       tag_q;
  logic [TX_PROD_W-1:0]   tx_prod_q;
  logic [TIME_W-1:0]      qmax_q;
  logic                   tdrop_q;

  // Result word.
  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic [TAG_W-1:0]       otag_q, otag_d;
  logic [LEN_W-1:0]       olen_q, olen_d;
  logic [TIME_W-1:0]      oarr_q, oarr_d;

  logic                   accept;
  logic                   recalc;
  logic                   win_busy;
  logic [WAIT_W-1:0]      win_wait;
  logic [TIME_W-1:0]      delay;
  logic                   tdrop;
  logic [TIME_W-1:0]      qc_new;
  logic [TIME_W-1:0]      arr_new;
  logic [TIME_W-1:0]      bend_new;
  logic                   fifo_full;
  logic                   push;
  logic                   drop;
  logic [PTR_W-1:0]       tail_next;
  logic [PTR_W-1:0]       head_next;
  fifo_entry_t            wr_entry;
  fifo_entry_t            rd_entry;

  assign busy_o = (state_q != CORE_IDLE) || win_busy;
  assign accept = start_i && !busy_o;
  assign recalc = cfg_we_i && ((cfg_idx_e'(cfg_idx_i) == CFG_TIME_PER_BYTE) ||
                               (cfg_idx_e'(cfg_idx_i) == CFG_BURST_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q       <= '0;
      latency_q   <= '0;
      max_delay_q <= '0;
      max_len_q   <= LEN_W'(MAX_LEN_RESET);
      burst_cnt_q <= '0;
      burst_gap_q <= '0;
      link_off_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_PER_BYTE:   tpb_q       <= cfg_data_i[STPB_W-1:0];
        CFG_LINK_LATENCY:    latency_q   <= cfg_data_i[LAT_W-1:0];
        CFG_MAX_QUEUE_DELAY: max_delay_q <= cfg_data_i[CNT_W-1:0];
        CFG_MAX_PKT_LEN:     max_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_BURST_COUNT:     burst_cnt_q <= cfg_data_i[BURST_CNT_W-1:0];
        CFG_BURST_SPACING:   burst_gap_q <= cfg_data_i[CNT_W-1:0];
        CFG_LINK_OFF:        link_off_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  lde_win u_win (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .recalc_i        (recalc),
    .time_per_byte_i (tpb_q),
    .burst_count_i   (burst_cnt_q),
    .busy_o          (win_busy),
    .wait_o          (win_wait)
  );

  assign wr_entry = '{arrival: arr_new, length: len_q, tag: tag_q};

  lde_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (push),
    .wr_addr_i (tail_q),
    .wr_data_i (wr_entry),
    .rd_en_i   (accept),
    .rd_addr_i (head_q),
    .rd_data_o (rd_entry)
  );

  // Accept stage: queue delay check and the transmit-time product.
  assign delay = (qc_q > now_i) ? (qc_q - now_i) : '0;
  assign tdrop = (max_delay_q != '0) && (delay >= TIME_W'(max_delay_q));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_e'(kind_i);
      now_q     <= now_i;
      len_q     <= packet_length_i;
      tag_q     <= packet_tag_i;
      tx_prod_q <= TX_PROD_W'(tpb_q) * TX_PROD_W'(packet_length_i);
      qmax_q    <= (now_i > qc_q) ? now_i : qc_q;
      tdrop_q   <= tdrop;
    end
  end

  assign qc_new    = sat_add_time(qmax_q, TIME_W'(tx_prod_q[TX_PROD_W-1:TX_SHIFT]));
  assign arr_new   = sat_add_time(qc_new, TIME_W'(latency_q));
  assign bend_new  = sat_add_time(now_q, TIME_W'(win_wait));
  assign fifo_full = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign tail_next = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
  assign head_next = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CORE_IDLE;
      done_q    <= 1'b0;
      qc_q      <= '0;
      sent_q    <= '0;
      dropped_q <= '0;
      rot_q     <= '0;
      mark_q    <= '0;
      left_q    <= '0;
      bend_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      qc_q      <= qc_d;
      sent_q    <= sent_d;
      dropped_q <= dropped_d;
      rot_q     <= rot_d;
      mark_q    <= mark_d;
      left_q    <= left_d;
      bend_q    <= bend_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    otag_q   <= otag_d;
    olen_q   <= olen_d;
    oarr_q   <= oarr_d;
  end

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    status_d  = status_q;
    otag_d    = otag_q;
    olen_d    = olen_q;
    oarr_d    = oarr_q;
    qc_d      = qc_q;
    sent_d    = sent_q;
    dropped_d = dropped_q;
    rot_d     = rot_q;
    mark_d    = mark_q;
    left_d    = left_q;
    bend_d    = bend_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    push      = 1'b0;
    drop      = 1'b0;
    case (state_q)
      CORE_IDLE: begin
        if (accept) begin
          state_d = CORE_EXEC;
        end
      end
      CORE_EXEC: begin
        state_d = CORE_IDLE;
        done_d  = 1'b1;
        otag_d  = '0;
        olen_d  = '0;
        oarr_d  = '0;
        if (kind_q == KIND_SUBMIT) begin
          drop = 1'b1;
          if (tdrop_q) begin
            status_d = ST_TAIL_DROP;
          end else if (fifo_full) begin
            status_d = ST_FIFO_FULL;
          end else begin
            qc_d = qc_new;
            if (len_q > max_len_q) begin
              status_d = ST_OVERSIZE;
            end else begin
              // The pattern advances only for packets that pass the size check.
              rot_d = {rot_q[0], rot_q[63:1]};
              if (rot_q[0]) begin
                status_d = ST_PATTERN_LOSS;
              end else if (link_off_q) begin
                status_d = ST_LINK_OFF;
              end else if ((burst_cnt_q != '0) && (sent_q > mark_q)) begin
                status_d = ST_BURST_LOSS;
                mark_d   = sat_add_cnt(sent_q, burst_gap_q);
                left_d   = burst_cnt_q - BURST_CNT_W'(1);
                bend_d   = bend_new;
              end else if ((burst_cnt_q != '0) && (left_q != '0) && !(now_q > bend_q)) begin
                status_d = ST_BURST_LOSS;
                left_d   = left_q - BURST_CNT_W'(1);
              end else begin
                // A burst that ran past its window ends here, and the packet passes.
                if ((burst_cnt_q != '0) && (left_q != '0)) begin
                  left_d = '0;
                end
                status_d = ST_QUEUED;
                drop     = 1'b0;
                push     = 1'b1;
                sent_d   = sat_add_cnt(sent_q, CNT_W'(1));
                tail_d   = tail_next;
                fill_d   = fill_q + FILL_W'(1);
                oarr_d   = arr_new;
              end
            end
          end
          if (drop) begin
            dropped_d = sat_add_cnt(dropped_q, CNT_W'(1));
          end
        end else begin
          if ((fill_q != '0) && (rd_entry.arrival <= now_q)) begin
            status_d = ST_DELIVERED;
            otag_d   = rd_entry.tag;
            olen_d   = rd_entry.length;
            oarr_d   = rd_entry.arrival;
            head_d   = head_next;
            fill_d   = fill_q - FILL_W'(1);
          end else begin
            status_d = ST_NONE_DUE;
          end
        end
      end
      default: begin
        state_d = CORE_IDLE;
      end
    endcase
    // Writing the loss pattern reloads the rotating register.
    if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_LOSS_PATTERN)) begin
      rot_d = cfg_data_i;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_tag_o       = otag_q;
  assign out_length_o    = olen_q;
  assign arrival_stamp_o = oarr_q;
  assign drop_total_o    = dropped_q;

  `ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_q <= FILL_W'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_empty_ptrs, fill_q == '0, head_q == tail_q)
  `ASSERT_NEXT(a_exec_done, state_q == CORE_EXEC, done_o && !busy_o || done_o && win_busy)
  `ASSERT_IMPLIES(a_done_idle, done_o, state_q == CORE_IDLE)

endmodule

`default_nettype wire

// ===== verif/tb_link_delay_loss_emulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_link_delay_loss_emulator
// Self-checking bench for the link emulator. A directed opening covers empty
// polls, size limits, tail drop, pattern, switch-off and burst loss. Random
// phases under different link setups and sender gaps follow. A saturated
// clock closes the run. Every result word is checked against a predictor.
// ----------------------------------------------------------------------------

import lde_pkg::*;

typedef struct {
  status_e           status;
  logic [TAG_W-1:0]  tag;
  logic [LEN_W-1:0]  length;
  logic [TIME_W-1:0] arrival;
  logic [CNT_W-1:0]  drops;
} link_word_t;

class link_tracker;
  localparam int unsigned DEPTH = 64;

  // Link setup.
  bit [STPB_W-1:0]      time_per_byte;
  bit [LAT_W-1:0]       latency;
  bit [31:0]            max_qdelay;
  bit [LEN_W-1:0]       max_len;
  bit [BURST_CNT_W-1:0] burst_count;
  bit [31:0]            burst_spacing;
  bit                   link_off;

  // Link state.
  bit [TIME_W-1:0]      queue_clock;
  bit [CNT_W-1:0]       sent;
  bit [CNT_W-1:0]       dropped;
  bit [63:0]            rotator;
  bit [31:0]            burst_mark;
  bit [BURST_CNT_W-1:0] burst_left;
  bit [TIME_W-1:0]      burst_end;
  fifo_entry_t          queued_packets[$];

  link_word_t  awaited_words[$];
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned status_seen[16];

  function new();
    max_len = MAX_LEN_RESET;
  endfunction

  function bit [TIME_W-1:0] sat48(bit [63:0] a, bit [63:0] b);
    bit [63:0] s;
    s = {16'b0, a[TIME_W-1:0]} + {16'b0, b[TIME_W-1:0]};
    return (s > 64'hFFFF_FFFF_FFFF) ? '1 : s[TIME_W-1:0];
  endfunction

  function bit [31:0] sat32(bit [31:0] a, bit [31:0] b);
    bit [63:0] s;
    s = {32'b0, a} + {32'b0, b};
    return (s > 64'hFFFF_FFFF) ? '1 : s[31:0];
  endfunction

  function void apply_setting(cfg_idx_e idx, bit [63:0] value);
    case (idx)
      CFG_TIME_PER_BYTE:   time_per_byte = value[STPB_W-1:0];
      CFG_LINK_LATENCY:    latency = value[LAT_W-1:0];
      CFG_MAX_QUEUE_DELAY: max_qdelay = value[31:0];
      CFG_MAX_PKT_LEN:     max_len = value[LEN_W-1:0];
      CFG_BURST_COUNT:     burst_count = value[BURST_CNT_W-1:0];
      CFG_BURST_SPACING:   burst_spacing = value[31:0];
      CFG_LOSS_PATTERN:    rotator = value;
      CFG_LINK_OFF:        link_off = value[0];
      default: begin
      end
    endcase
  endfunction

  function bit pattern_hits();
    bit lsb;
    lsb = rotator[0];
    rotator = {lsb, rotator[63:1]};
    return lsb;
  endfunction

  function bit burst_hits(bit [TIME_W-1:0] now);
    bit [63:0] window;
    if (burst_count == 0) return 1'b0;
    if (sent > burst_mark) begin
      window = 64'(burst_count) * 64'(time_per_byte) * 64'(BURST_BYTES);
      burst_mark = sat32(sent, burst_spacing);
      burst_left = burst_count - 8'd1;
      burst_end = sat48(now, window / 64'(BURST_DIVISOR));
      return 1'b1;
    end
    if (burst_left > 0) begin
      // A packet that comes after the window closes ends the burst.
      if (now > burst_end) begin
        burst_left = '0;
        return 1'b0;
      end
      burst_left = burst_left - 8'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void take_command(kind_e kind, bit [TIME_W-1:0] now, bit [LEN_W-1:0] len,
                             bit [TAG_W-1:0] tag);
    link_word_t  w;
    bit [TIME_W-1:0] delay;
    bit [63:0]   tx;
    fifo_entry_t e;
    w.status = ST_NONE_DUE;
    w.tag = '0;
    w.length = '0;
    w.arrival = '0;
    if (kind == KIND_SUBMIT) begin
      delay = (queue_clock > now) ? queue_clock - now : '0;
      if (max_qdelay != 0 && delay >= max_qdelay) begin
        w.status = ST_TAIL_DROP;
      end else if (queued_packets.size() >= DEPTH) begin
        w.status = ST_FIFO_FULL;
      end else begin
        tx = ({24'b0, time_per_byte} * {48'b0, len}) >> TX_SHIFT;
        if (now > queue_clock) queue_clock = now;
        queue_clock = sat48(queue_clock, tx);
        if (len > max_len) w.status = ST_OVERSIZE;
        else if (pattern_hits()) w.status = ST_PATTERN_LOSS;
        else if (link_off) w.status = ST_LINK_OFF;
        else if (burst_hits(now)) w.status = ST_BURST_LOSS;
        else begin
          w.status = ST_QUEUED;
          e.arrival = sat48(queue_clock, latency);
          e.length = len;
          e.tag = tag;
          queued_packets.push_back(e);
          sent = sat32(sent, 1);
          w.arrival = e.arrival;
        end
      end
      if (w.status != ST_QUEUED) dropped = sat32(dropped, 1);
    end else if (queued_packets.size() != 0 && queued_packets[0].arrival <= now) begin
      e = queued_packets.pop_front();
      w.status = ST_DELIVERED;
      w.tag = e.tag;
      w.length = e.length;
      w.arrival = e.arrival;
    end
    w.drops = dropped;
    awaited_words.push_back(w);
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  task check_word(logic [STATUS_W-1:0] st, logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len,
                  logic [TIME_W-1:0] arr, logic [CNT_W-1:0] drops);
    link_word_t w;
    if (awaited_words.size() == 0) begin
      report_mismatch($sformatf("word with status %0d but nothing outstanding", st));
      return;
    end
    w = awaited_words.pop_front();
    words_checked++;
    status_seen[w.status]++;
    if (st !== w.status)
      report_mismatch($sformatf("word %0d status %0d, want %0d", words_checked, st, w.status));
    if (tag !== w.tag)
      report_mismatch($sformatf("word %0d tag %h, want %h", words_checked, tag, w.tag));
    if (len !== w.length)
      report_mismatch($sformatf("word %0d length %0d, want %0d", words_checked, len,
                                w.length));
    if (arr !== w.arrival)
      report_mismatch($sformatf("word %0d arrival %0d, want %0d", words_checked, arr,
                                w.arrival));
    if (drops !== w.drops)
      report_mismatch($sformatf("word %0d drop total %0d, want %0d", words_checked, drops,
                                w.drops));
  endtask
endclass

module tb_link_delay_loss_emulator;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic                  kind_i = 1'b0;
  logic [TIME_W-1:0]     now_i = '0;
  logic [LEN_W-1:0]      packet_length_i = '0;
  logic [TAG_W-1:0]      packet_tag_i = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [TAG_W-1:0]      out_tag_o;
  logic [LEN_W-1:0]      out_length_o;
  logic [TIME_W-1:0]     arrival_stamp_o;
  logic [CNT_W-1:0]      drop_total_o;

  link_tracker       tracker;
  int unsigned       commands_sent;
  int unsigned       quiet_cycles;
  logic [TIME_W-1:0] link_time;

  link_delay_loss_emulator #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .now_i          (now_i),
    .packet_length_i(packet_length_i),
    .packet_tag_i   (packet_tag_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_length_o   (out_length_o),
    .arrival_stamp_o(arrival_stamp_o),
    .drop_total_o   (drop_total_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result words are checked here; any edge that moves a word or a register
  // write counts as progress for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1)
        tracker.check_word(status_o, out_tag_o, out_length_o, arrival_stamp_o, drop_total_o);
      if ((start_i && busy_o === 1'b0) || done_o === 1'b1 || cfg_we_i) begin
        quiet_cycles = 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[%0t] Watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Leaves start high so that a following command can go out back to back.
  task automatic issue(kind_e kind, logic [TIME_W-1:0] now, logic [LEN_W-1:0] len,
                       logic [TAG_W-1:0] tag);
    start_i <= 1'b1;
    kind_i <= kind;
    now_i <= now;
    packet_length_i <= len;
    packet_tag_i <= tag;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    tracker.take_command(kind, now, len, tag);
    commands_sent++;
  endtask

  task automatic pause(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_setting(cfg_idx_e idx, logic [63:0] value);
    start_i <= 1'b0;
    while (busy_o !== 1'b0 || tracker.awaited_words.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    tracker.apply_setting(idx, value);
    cfg_we_i <= 1'b0;
    // Give the burst window divider time to raise busy.
    repeat (2) @(posedge clk_i);
  endtask

  task automatic link_setup(logic [63:0] per_byte, logic [63:0] lat, logic [63:0] qdelay,
                            logic [63:0] size_limit, logic [63:0] burst, logic [63:0] spacing,
                            logic [63:0] pattern, logic [63:0] off);
    write_setting(CFG_TIME_PER_BYTE, per_byte);
    write_setting(CFG_LINK_LATENCY, lat);
    write_setting(CFG_MAX_QUEUE_DELAY, qdelay);
    write_setting(CFG_MAX_PKT_LEN, size_limit);
    write_setting(CFG_BURST_COUNT, burst);
    write_setting(CFG_BURST_SPACING, spacing);
    write_setting(CFG_LOSS_PATTERN, pattern);
    write_setting(CFG_LINK_OFF, off);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return LEN_W'($urandom);
    if (r < 14) return tracker.max_len + LEN_W'($urandom_range(1));
    return LEN_W'($urandom_range(1600));
  endfunction

  // Most submits follow a rising link time; most polls aim at the head
  // packet's arrival, just before or after it, so deliveries stay frequent.
  task automatic run_phase(int unsigned count, int unsigned idle_pct, int unsigned poll_pct,
                           int unsigned span);
    logic [TIME_W-1:0] now;
    logic [63:0]       t;
    int unsigned       r;
    repeat (count) begin
      if ($urandom_range(99) < idle_pct) pause($urandom_range(1, 6));
      r = $urandom_range(99);
      if (r < 3) begin
        issue(KIND_POLL, TIME_W'({$urandom, $urandom}), pick_length(), TAG_W'($urandom));
      end else if (r < poll_pct) begin
        now = link_time;
        if (tracker.queued_packets.size() != 0 && $urandom_range(9) < 7) begin
          t = {16'b0, tracker.queued_packets[0].arrival};
          if ($urandom_range(3) == 0) t = (t > 2) ? t - $urandom_range(1, 2) : t;
          else t = t + $urandom_range(span);
          now = (t > {16'b0, TIME_MAX}) ? TIME_MAX : t[TIME_W-1:0];
        end
        issue(KIND_POLL, now, LEN_W'($urandom), TAG_W'($urandom));
      end else begin
        link_time = link_time + $urandom_range(span);
        if ($urandom_range(9) == 0 && tracker.queue_clock > link_time)
          link_time = tracker.queue_clock;
        now = link_time;
        if ($urandom_range(19) == 0 && link_time > 100) now = link_time - $urandom_range(100);
        issue(KIND_SUBMIT, now, pick_length(), TAG_W'($urandom));
      end
    end
  endtask

  initial begin
    tracker = new();
    link_time = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, then lengths around the reset size limit.
    issue(KIND_POLL, '0, '0, '0);
    issue(KIND_SUBMIT, '0, '0, '0);
    issue(KIND_SUBMIT, '0, 16'd1536, 16'hFFFF);
    issue(KIND_SUBMIT, '0, 16'd1537, 16'h1234);
    issue(KIND_SUBMIT, '0, 16'hFFFF, 16'h4321);
    issue(KIND_POLL, '0, 16'hFFFF, 16'hFFFF);
    issue(KIND_POLL, TIME_MAX, '0, '0);
    issue(KIND_POLL, TIME_MAX, '0, '0);

    // One microsecond per byte: the third packet sees too long a queue.
    write_setting(CFG_TIME_PER_BYTE, 64'd1 << 20);
    write_setting(CFG_LINK_LATENCY, 64'd100);
    write_setting(CFG_MAX_QUEUE_DELAY, 64'd500);
    issue(KIND_SUBMIT, 48'd1000, 16'd400, 16'd1);
    issue(KIND_SUBMIT, 48'd1000, 16'd200, 16'd2);
    issue(KIND_SUBMIT, 48'd1000, 16'd100, 16'd3);
    issue(KIND_POLL, 48'd1499, '0, '0);
    issue(KIND_POLL, 48'd1500, '0, '0);

    // The pattern must not rotate on an oversize packet.
    write_setting(CFG_LOSS_PATTERN, 64'h5);
    issue(KIND_SUBMIT, 48'd5000, 16'd10, 16'd4);
    issue(KIND_SUBMIT, 48'd5000, 16'd2000, 16'd5);
    issue(KIND_SUBMIT, 48'd5000, 16'd10, 16'd6);
    issue(KIND_SUBMIT, 48'd5000, 16'd10, 16'd7);
    write_setting(CFG_LINK_OFF, 64'd1);
    issue(KIND_SUBMIT, 48'd6000, 16'd10, 16'd8);

    // Burst start, continuation, two passes, and a second start.
    write_setting(CFG_LINK_OFF, 64'd0);
    write_setting(CFG_BURST_COUNT, 64'd2);
    write_setting(CFG_BURST_SPACING, 64'd1);
    issue(KIND_SUBMIT, 48'd7000, 16'd10, 16'd9);
    issue(KIND_SUBMIT, 48'd7010, 16'd10, 16'd10);
    issue(KIND_SUBMIT, 48'd7020, 16'd10, 16'd11);
    issue(KIND_SUBMIT, 48'd7030, 16'd10, 16'd12);
    issue(KIND_SUBMIT, 48'd20000, 16'd10, 16'd13);

    link_setup(64'd1 << 20, 64'd2000, 64'd20000, 64'd1500, 64'd3, 64'd12,
               64'h8000_0000_0000_0011, 64'd0);
    run_phase(130, 0, 40, 600);

    link_setup(64'd0, 64'd0, 64'd0, 64'd65535, 64'd255, 64'd0, 64'd0, 64'd0);
    run_phase(130, 55, 45, 50);

    // Sparse losses, huge latency and few polls let the queue fill up.
    link_setup(64'd1 << 22, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'd1536, 64'd1, 64'hFFFF_FFFF,
               {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom}, 64'd0);
    run_phase(140, 0, 20, 3000);

    link_setup((64'd1 << 40) - 1, 64'd777, 64'h4000_0000, 64'd65535, 64'd2, 64'd5,
               {$urandom, $urandom}, 64'd0);
    run_phase(130, 11, 45, 32'h8000_0000);

    // A saturated queue clock never comes back down, so this part goes last.
    link_setup((64'd1 << 40) - 1, 64'hFFFF_FFFF, 64'd0, 64'd65535, 64'd1, 64'd0, 64'd0,
               64'd0);
    repeat (DEPTH + 2) issue(KIND_POLL, TIME_MAX, LEN_W'($urandom), TAG_W'($urandom));
    repeat (3) issue(KIND_SUBMIT, TIME_MAX - 1, 16'hFFFF, TAG_W'($urandom));
    issue(KIND_POLL, TIME_MAX - 1, '0, '0);
    issue(KIND_POLL, TIME_MAX, '0, '0);
    write_setting(CFG_MAX_QUEUE_DELAY, 64'd1);
    issue(KIND_SUBMIT, '0, 16'd64, 16'hA5A5);
    write_setting(CFG_MAX_QUEUE_DELAY, 64'd0);
    repeat (2) begin
      repeat (12) begin
        if ($urandom_range(99) < 11) pause($urandom_range(1, 6));
        issue(kind_e'($urandom_range(1)), TIME_W'({$urandom, $urandom}), LEN_W'($urandom),
              TAG_W'($urandom));
      end
      write_setting(CFG_LINK_OFF, 64'd1);
    end

    start_i <= 1'b0;
    while (tracker.awaited_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.awaited_words.size() != 0)
      tracker.report_mismatch($sformatf("%0d words never arrived",
                                        tracker.awaited_words.size()));

    $display("Sent %0d commands over five link setups; %0d result words compared.",
             commands_sent, tracker.words_checked);
    $display("Queued %0d, delivered %0d, none due %0d, tail %0d, full %0d, size %0d, %s%0d",
             tracker.status_seen[ST_QUEUED], tracker.status_seen[ST_DELIVERED],
             tracker.status_seen[ST_NONE_DUE], tracker.status_seen[ST_TAIL_DROP],
             tracker.status_seen[ST_FIFO_FULL], tracker.status_seen[ST_OVERSIZE],
             "pattern/off/burst ", tracker.status_seen[ST_PATTERN_LOSS]
             + tracker.status_seen[ST_LINK_OFF] + tracker.status_seen[ST_BURST_LOSS]);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
